>>> src/dapm_pkg.sv
// ----------------------------------------------------------------------------
// Dual-axis PID move controller - shared definitions
// Codes, fixed widths, constants and the structs that pass between the stages.
// ----------------------------------------------------------------------------
package dapm_pkg;

   // Request kinds carried on req_tuser
   typedef enum logic [1:0] {
      ACT_TICK   = 2'd0,
      ACT_DRIVE  = 2'd1,
      ACT_ROTATE = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      MOTOR_HOLD = 2'd0,
      MOTOR_SPIN = 2'd1,
      MOTOR_STOP = 2'd2
   } motor_cmd_type;

   typedef enum logic [1:0] {
      SENSE_NONE    = 2'd0,
      SENSE_WHEELS  = 2'd1,
      SENSE_HEADING = 2'd2
   } sensor_reset_type;

   // Control register indexes
   typedef enum logic [2:0] {
      CSR_LAT_GAIN_P = 3'd0,
      CSR_LAT_GAIN_I = 3'd1,
      CSR_LAT_GAIN_D = 3'd2,
      CSR_ROT_GAIN_P = 3'd3,
      CSR_ROT_GAIN_I = 3'd4,
      CSR_ROT_GAIN_D = 3'd5,
      CSR_LAT_TOL    = 3'd6,
      CSR_ROT_TOL    = 3'd7
   } csr_index_type;

   // Field and state widths
   localparam int GAIN_W     = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int ROT_TOL_W  = 13;
   localparam int TARGET_W   = 17;
   localparam int ENC_W      = 32;
   localparam int HEAD_W     = 13;
   localparam int DRIVE_W    = 16;
   localparam int LAT_TGT_W  = 23;
   localparam int POS_SUM_W  = 35;
   localparam int POS_W      = 33;
   localparam int LAT_ERR_W  = 35;
   localparam int LAT_DER_W  = 36;
   localparam int LAT_INT_W  = 48;
   localparam int ROT_TGT_W  = 13;
   localparam int HEAD_UW_W  = 15;
   localparam int ROT_ERR_W  = 16;
   localparam int ROT_DER_W  = 17;
   localparam int ROT_INT_W  = 32;

   // Fixed constants
   localparam logic signed [21:0]        DRIVE_K_Q16 = 22'sd1877468; // 360/circumference
   localparam logic signed [TARGET_W-1:0] FULL_TURN_T = 17'sd5760;
   localparam logic [HEAD_W-1:0]         UNWRAP_LOW   = 13'd1440;
   localparam logic [HEAD_W-1:0]         UNWRAP_HIGH  = 13'd4320;
   localparam logic signed [HEAD_UW_W-1:0] FULL_TURN_H = 15'sd5760;
   localparam logic [GAIN_W-1:0]         FINE_D_GAIN  = 16'd29491;
   localparam logic signed [ROT_ERR_W-1:0] FINE_BAND  = 16'sd80;
   localparam logic [1:0]                SETTLE_LAST  = 2'd2;
   localparam int                        DRIVE_MAX    = 25600;

   typedef struct packed {
      logic [GAIN_W-1:0]    lat_gain_p;
      logic [GAIN_W-1:0]    lat_gain_i;
      logic [GAIN_W-1:0]    lat_gain_d;
      logic [GAIN_W-1:0]    rot_gain_p;
      logic [GAIN_W-1:0]    rot_gain_i;
      logic [GAIN_W-1:0]    rot_gain_d;
      logic [GAIN_W-1:0]    lat_tol;
      logic [ROT_TOL_W-1:0] rot_tol;
   } cfg_type;

   typedef struct packed {
      logic [1:0]                 action;
      logic signed [TARGET_W-1:0] move_target;
      logic                       fine_damping;
      logic signed [ENC_W-1:0]    left_pos_a;
      logic signed [ENC_W-1:0]    left_pos_b;
      logic signed [ENC_W-1:0]    right_pos_a;
      logic signed [ENC_W-1:0]    right_pos_b;
      logic [HEAD_W-1:0]          heading;
   } req_type;

   // Operands and status handed from the control stage to the drive stage
   typedef struct packed {
      logic signed [LAT_ERR_W-1:0] err;
      logic signed [LAT_INT_W-1:0] integ;
      logic signed [LAT_DER_W-1:0] deriv;
      logic [GAIN_W-1:0]           gain_p;
      logic [GAIN_W-1:0]           gain_i;
      logic [GAIN_W-1:0]           gain_d;
      logic                        lateral;
      motor_cmd_type               cmd;
      sensor_reset_type            sense;
      logic                        done;
   } drive_op_type;

endpackage

>>> src/dapm_cfg_regs.sv
// ----------------------------------------------------------------------------
// Dual-axis PID move controller - control registers
// Gains and settle bands, loaded by index from the write port.
// ----------------------------------------------------------------------------
module dapm_cfg_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [dapm_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [dapm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output dapm_pkg::cfg_type                cfg
);
   import dapm_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_LAT_GAIN_P: cfg_in.lat_gain_p = csr_wdata;
            CSR_LAT_GAIN_I: cfg_in.lat_gain_i = csr_wdata;
            CSR_LAT_GAIN_D: cfg_in.lat_gain_d = csr_wdata;
            CSR_ROT_GAIN_P: cfg_in.rot_gain_p = csr_wdata;
            CSR_ROT_GAIN_I: cfg_in.rot_gain_i = csr_wdata;
            CSR_ROT_GAIN_D: cfg_in.rot_gain_d = csr_wdata;
            CSR_LAT_TOL:    cfg_in.lat_tol    = csr_wdata;
            CSR_ROT_TOL:    cfg_in.rot_tol    = csr_wdata[ROT_TOL_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // Load defaults on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lat_gain_p <= 16'd6554;
         cfg_ff.lat_gain_i <= 16'd0;
         cfg_ff.lat_gain_d <= 16'd0;
         cfg_ff.rot_gain_p <= 16'd24379;
         cfg_ff.rot_gain_i <= 16'd341;
         cfg_ff.rot_gain_d <= 16'd13107;
         cfg_ff.lat_tol    <= 16'd400;
         cfg_ff.rot_tol    <= 13'd48;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/dapm_ctrl.sv
// ----------------------------------------------------------------------------
// Dual-axis PID move controller - control stage
// Computes errors, picks the active loop, updates move state and integrals,
// and registers the multiplier operands for the drive stage.
// ----------------------------------------------------------------------------
module dapm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  dapm_pkg::cfg_type      cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  dapm_pkg::req_type      req,
   output logic                   op_valid,
   input  logic                   op_ready,
   output dapm_pkg::drive_op_type op
);
   import dapm_pkg::*;

   // Move state
   logic signed [LAT_TGT_W-1:0] lat_tgt_ff, lat_tgt_in;
   logic [ROT_TGT_W-1:0]        rot_tgt_ff, rot_tgt_in;
   logic                        turn_left_ff, turn_left_in;
   logic signed [LAT_ERR_W-1:0] lat_last_ff, lat_last_in;
   logic signed [ROT_ERR_W-1:0] rot_last_ff, rot_last_in;
   logic signed [LAT_INT_W-1:0] lat_int_ff, lat_int_in;
   logic signed [ROT_INT_W-1:0] rot_int_ff, rot_int_in;
   logic [1:0]                  settle_ff, settle_in;
   logic                        moving_ff, moving_in;

   drive_op_type op_ff, op_in;
   logic         op_valid_ff, op_valid_in;
   logic         in_fire;

   // Datapath
   logic signed [38:0]           drv_prod;
   logic signed [38:0]           drv_rnd;
   logic signed [TARGET_W-1:0]   ang_clamp;
   logic signed [13:0]           ang;
   logic signed [POS_SUM_W-1:0]  pos_sum;
   logic signed [POS_W-1:0]      pos;
   logic signed [LAT_ERR_W-1:0]  lat_err;
   logic [LAT_ERR_W-1:0]         lat_abs;
   logic                         lat_active;
   logic signed [LAT_DER_W-1:0]  lat_der;
   logic signed [LAT_INT_W:0]    lat_int_sum;
   logic signed [LAT_INT_W-1:0]  lat_int_sat;
   logic signed [HEAD_UW_W-1:0]  head_uw;
   logic signed [ROT_ERR_W-1:0]  rot_err;
   logic [ROT_ERR_W-1:0]         rot_abs;
   logic                         rot_active;
   logic signed [ROT_DER_W-1:0]  rot_der;
   logic signed [ROT_INT_W:0]    rot_int_sum;
   logic signed [ROT_INT_W-1:0]  rot_int_sat;

   assign in_fire  = in_valid && in_ready;
   assign in_ready = !op_valid_ff || op_ready;

   // Drive distance to encoder target, rounded to nearest
   always_comb begin
      drv_prod = req.move_target * DRIVE_K_Q16;
      drv_rnd  = drv_prod + 39'sd32768;
   end

   // Clamp the turn angle to one revolution
   always_comb begin
      if (req.move_target < -FULL_TURN_T) begin
         ang_clamp = -FULL_TURN_T;
      end else if (req.move_target > FULL_TURN_T) begin
         ang_clamp = FULL_TURN_T;
      end else begin
         ang_clamp = req.move_target;
      end
      ang = ang_clamp[13:0];
   end

   // Lateral error from the four wheel encoders
   always_comb begin
      pos_sum = POS_SUM_W'(req.right_pos_a) + POS_SUM_W'(req.right_pos_b)
              - POS_SUM_W'(req.left_pos_a) - POS_SUM_W'(req.left_pos_b) + 35'sd2;
      pos     = pos_sum[POS_SUM_W-1:2];
      lat_err = LAT_ERR_W'(lat_tgt_ff) - LAT_ERR_W'(pos);
      lat_abs = lat_err[LAT_ERR_W-1] ? LAT_ERR_W'(-lat_err) : LAT_ERR_W'(lat_err);
      lat_active = (lat_tgt_ff != '0) && (lat_abs > LAT_ERR_W'(cfg.lat_tol));
      lat_der = LAT_DER_W'(lat_err) - LAT_DER_W'(lat_last_ff);
      lat_int_sum = (LAT_INT_W+1)'(lat_int_ff) + (LAT_INT_W+1)'(lat_err);
      if (lat_int_sum[LAT_INT_W] != lat_int_sum[LAT_INT_W-1]) begin
         lat_int_sat = {lat_int_sum[LAT_INT_W], {(LAT_INT_W-1){!lat_int_sum[LAT_INT_W]}}};
      end else begin
         lat_int_sat = lat_int_sum[LAT_INT_W-1:0];
      end
   end

   // Heading error, unwrapped toward the turn direction
   always_comb begin
      head_uw = $signed({2'b00, req.heading});
      if (turn_left_ff && (req.heading <= UNWRAP_LOW)) begin
         head_uw = head_uw + FULL_TURN_H;
      end else if (!turn_left_ff && (req.heading >= UNWRAP_HIGH)) begin
         head_uw = head_uw - FULL_TURN_H;
      end
      rot_err = $signed({3'b000, rot_tgt_ff}) - ROT_ERR_W'(head_uw);
      rot_abs = rot_err[ROT_ERR_W-1] ? ROT_ERR_W'(-rot_err) : ROT_ERR_W'(rot_err);
      rot_active = (rot_tgt_ff != '0) && (rot_abs > ROT_ERR_W'(cfg.rot_tol));
      rot_der = ROT_DER_W'(rot_err) - ROT_DER_W'(rot_last_ff);
      rot_int_sum = (ROT_INT_W+1)'(rot_int_ff) + (ROT_INT_W+1)'(rot_err);
      if (rot_int_sum[ROT_INT_W] != rot_int_sum[ROT_INT_W-1]) begin
         rot_int_sat = {rot_int_sum[ROT_INT_W], {(ROT_INT_W-1){!rot_int_sum[ROT_INT_W]}}};
      end else begin
         rot_int_sat = rot_int_sum[ROT_INT_W-1:0];
      end
   end

   // Next move state and drive operands
   always_comb begin
      lat_tgt_in   = lat_tgt_ff;
      rot_tgt_in   = rot_tgt_ff;
      turn_left_in = turn_left_ff;
      lat_last_in  = lat_last_ff;
      rot_last_in  = rot_last_ff;
      lat_int_in   = lat_int_ff;
      rot_int_in   = rot_int_ff;
      settle_in    = settle_ff;
      moving_in    = moving_ff;
      op_in        = '0;
      op_in.cmd    = MOTOR_HOLD;
      op_in.sense  = SENSE_NONE;
      if (in_fire) begin
         unique case (action_type'(req.action))
            ACT_DRIVE: begin
               lat_tgt_in  = -drv_rnd[38:16];
               moving_in   = 1'b1;
               op_in.sense = SENSE_WHEELS;
            end
            ACT_ROTATE: begin
               rot_tgt_in   = ang[13] ? ROT_TGT_W'(ang + 14'sd5760) : ROT_TGT_W'(ang);
               turn_left_in = ang[13];
               moving_in    = 1'b1;
               op_in.sense  = SENSE_HEADING;
            end
            ACT_TICK: begin
               if (moving_ff) begin
                  priority if (lat_active) begin
                     settle_in     = 2'd0;
                     lat_int_in    = lat_int_sat;
                     lat_last_in   = lat_err;
                     op_in.err     = lat_err;
                     op_in.integ   = lat_int_sat;
                     op_in.deriv   = lat_der;
                     op_in.gain_p  = cfg.lat_gain_p;
                     op_in.gain_i  = cfg.lat_gain_i;
                     op_in.gain_d  = cfg.lat_gain_d;
                     op_in.lateral = 1'b1;
                     op_in.cmd     = MOTOR_SPIN;
                  end else if (rot_active) begin
                     settle_in     = 2'd0;
                     rot_int_in    = rot_int_sat;
                     rot_last_in   = rot_err;
                     op_in.err     = LAT_ERR_W'(rot_err);
                     op_in.integ   = LAT_INT_W'(rot_int_sat);
                     op_in.deriv   = LAT_DER_W'(rot_der);
                     op_in.gain_p  = cfg.rot_gain_p;
                     op_in.gain_i  = cfg.rot_gain_i;
                     op_in.gain_d  = (rot_err < FINE_BAND && req.fine_damping) ?
                                     FINE_D_GAIN : cfg.rot_gain_d;
                     op_in.lateral = 1'b0;
                     op_in.cmd     = MOTOR_SPIN;
                  end else if (settle_ff == SETTLE_LAST) begin
                     settle_in   = 2'd0;
                     moving_in   = 1'b0;
                     lat_tgt_in  = '0;
                     rot_tgt_in  = '0;
                     lat_last_in = '0;
                     rot_last_in = '0;
                     op_in.cmd   = MOTOR_STOP;
                  end else begin
                     settle_in = settle_ff + 2'd1;
                  end
               end
            end
            default: begin
               moving_in = moving_ff;
            end
         endcase
      end
      op_in.done = !moving_in;
   end

   // Drop the operand register once the drive stage takes it
   always_comb begin
      if (in_fire) begin
         op_valid_in = 1'b1;
      end else if (op_ready) begin
         op_valid_in = 1'b0;
      end else begin
         op_valid_in = op_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_tgt_ff   <= '0;
         rot_tgt_ff   <= '0;
         turn_left_ff <= 1'b0;
         lat_last_ff  <= '0;
         rot_last_ff  <= '0;
         lat_int_ff   <= '0;
         rot_int_ff   <= '0;
         settle_ff    <= '0;
         moving_ff    <= 1'b0;
         op_valid_ff  <= 1'b0;
      end else begin
         lat_tgt_ff   <= lat_tgt_in;
         rot_tgt_ff   <= rot_tgt_in;
         turn_left_ff <= turn_left_in;
         lat_last_ff  <= lat_last_in;
         rot_last_ff  <= rot_last_in;
         lat_int_ff   <= lat_int_in;
         rot_int_ff   <= rot_int_in;
         settle_ff    <= settle_in;
         moving_ff    <= moving_in;
         op_valid_ff  <= op_valid_in;
      end
   end

   // Hold operands while the drive stage is busy
   always_ff @(posedge clock) begin
      if (in_fire) begin
         op_ff <= op_in;
      end
   end

   assign op_valid = op_valid_ff;
   assign op       = op_ff;

   // An idle controller has no targets left behind
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !moving_ff |-> (lat_tgt_ff == '0) && (rot_tgt_ff == '0))
      else $error("targets left set while idle");

   a_settle_range: assert property (@(posedge clock) disable iff (reset)
      settle_ff != 2'd3)
      else $error("settle count overran");

   // A stop command always finishes the move
   a_stop_done: assert property (@(posedge clock) disable iff (reset)
      op_valid_ff && (op_ff.cmd == MOTOR_STOP) |-> op_ff.done && !moving_ff)
      else $error("stop issued with move still active");

endmodule

>>> src/dapm_drive.sv
// ----------------------------------------------------------------------------
// Dual-axis PID move controller - drive stage
// Weights error, integral and derivative by the gains, rounds, saturates and
// registers the motor commands.
// ----------------------------------------------------------------------------
module dapm_drive (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        op_valid,
   output logic                        op_ready,
   input  dapm_pkg::drive_op_type      op,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic signed [dapm_pkg::DRIVE_W-1:0] left_drive,
   output logic signed [dapm_pkg::DRIVE_W-1:0] right_drive,
   output dapm_pkg::motor_cmd_type     motor_cmd,
   output dapm_pkg::sensor_reset_type  sensor_reset,
   output logic                        move_done
);
   import dapm_pkg::*;

   localparam int TP_W  = LAT_ERR_W + GAIN_W + 1;
   localparam int TI_W  = LAT_INT_W + GAIN_W + 1;
   localparam int TD_W  = LAT_DER_W + GAIN_W + 1;
   localparam int SUM_W = TI_W + 1;
   localparam int SH_W  = SUM_W - 12;
   localparam logic signed [SH_W-1:0] SAT_HI = SH_W'(DRIVE_MAX);
   localparam logic signed [SH_W-1:0] SAT_LO = -SH_W'(DRIVE_MAX);

   logic signed [TP_W-1:0]    term_p;
   logic signed [TI_W-1:0]    term_i;
   logic signed [TD_W-1:0]    term_d;
   logic signed [SUM_W-1:0]   total;
   logic signed [SH_W-1:0]    scaled;
   logic signed [DRIVE_W-1:0] value;
   logic signed [DRIVE_W-1:0] left_in, right_in;

   logic signed [DRIVE_W-1:0] left_ff, right_ff;
   motor_cmd_type             cmd_ff;
   sensor_reset_type          sense_ff;
   logic                      done_ff;
   logic                      out_valid_ff, out_valid_in;
   logic                      op_fire;

   assign op_ready = !out_valid_ff || out_ready;
   assign op_fire  = op_valid && op_ready;

   // Weighted sum, rounded to nearest in 1/256 percent
   always_comb begin
      term_p = $signed(op.err)   * $signed({1'b0, op.gain_p});
      term_i = $signed(op.integ) * $signed({1'b0, op.gain_i});
      term_d = $signed(op.deriv) * $signed({1'b0, op.gain_d});
      total  = SUM_W'(term_p) + SUM_W'(term_i) + SUM_W'(term_d) + SUM_W'(2048);
      scaled = total[SUM_W-1:12];
   end

   // Saturate and steer to the wheels
   always_comb begin
      if (scaled > SAT_HI) begin
         value = DRIVE_W'(SAT_HI);
      end else if (scaled < SAT_LO) begin
         value = DRIVE_W'(SAT_LO);
      end else begin
         value = scaled[DRIVE_W-1:0];
      end
      if (op.cmd == MOTOR_SPIN) begin
         left_in  = op.lateral ? -value : value;
         right_in = value;
      end else begin
         left_in  = '0;
         right_in = '0;
      end
   end

   always_comb begin
      if (op_fire) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (op_fire) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         cmd_ff   <= op.cmd;
         sense_ff <= op.sense;
         done_ff  <= op.done;
      end
   end

   assign out_valid    = out_valid_ff;
   assign left_drive   = left_ff;
   assign right_drive  = right_ff;
   assign motor_cmd    = cmd_ff;
   assign sensor_reset = sense_ff;
   assign move_done    = done_ff;

   a_quiet_drives: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (cmd_ff != MOTOR_SPIN) |-> (left_ff == '0) && (right_ff == '0))
      else $error("drive nonzero without spin command");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (right_ff <= 16'sd25600) && (right_ff >= -16'sd25600))
      else $error("drive outside saturation band");

endmodule

>>> src/dual_axis_pid_move_controller.sv
// ----------------------------------------------------------------------------
// Dual-axis PID move controller - top level
// Lateral distance PID and rotational heading PID for a differential drive.
// ----------------------------------------------------------------------------
// Path: each request is registered in the input, control and drive stages.
// Throughput: one request per cycle unless rsp_tready stalls; move state and
//   integrals update in the control stage, so every request may follow the last.
// Reset: synchronous; clears the move state and integrals, empties the
//   pipeline and loads the default gains and settle bands.
module dual_axis_pid_move_controller (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // [16:0] move_target, [17] fine_damping, [49:18] left_pos_a,
   // [81:50] left_pos_b, [113:82] right_pos_a, [145:114] right_pos_b,
   // [158:146] heading, [159] zero
   input  logic [159:0] req_tdata,
   input  logic [1:0]   req_tuser,  // [1:0] action
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [15:0] left_drive, [31:16] right_drive, [33:32] motor_cmd,
   // [35:34] sensor_reset, [36] move_done, [39:37] zero
   output logic [39:0]  rsp_tdata,
   // control register port
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);
   import dapm_pkg::*;

   cfg_type          cfg;
   req_type          req_in, req_ff;
   logic             req_valid_ff, req_valid_in;
   logic             ctrl_ready;
   drive_op_type     op;
   logic             op_valid, op_ready;
   logic signed [DRIVE_W-1:0] left_drive, right_drive;
   motor_cmd_type    motor_cmd;
   sensor_reset_type sensor_reset;
   logic             move_done;

   dapm_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Unpack the request
   always_comb begin
      req_in.action       = req_tuser;
      req_in.move_target  = req_tdata[16:0];
      req_in.fine_damping = req_tdata[17];
      req_in.left_pos_a   = req_tdata[49:18];
      req_in.left_pos_b   = req_tdata[81:50];
      req_in.right_pos_a  = req_tdata[113:82];
      req_in.right_pos_b  = req_tdata[145:114];
      req_in.heading      = req_tdata[158:146];
   end

   // Input register
   assign req_tready = !req_valid_ff || ctrl_ready;

   always_comb begin
      if (req_tvalid && req_tready) begin
         req_valid_in = 1'b1;
      end else if (ctrl_ready) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff <= req_in;
      end
   end

   dapm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (req_valid_ff),
      .in_ready (ctrl_ready),
      .req      (req_ff),
      .op_valid (op_valid),
      .op_ready (op_ready),
      .op       (op)
   );

   dapm_drive u_drive (
      .clock        (clock),
      .reset        (reset),
      .op_valid     (op_valid),
      .op_ready     (op_ready),
      .op           (op),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .left_drive   (left_drive),
      .right_drive  (right_drive),
      .motor_cmd    (motor_cmd),
      .sensor_reset (sensor_reset),
      .move_done    (move_done)
   );

   // Pack the result
   assign rsp_tdata = {3'b000, move_done, sensor_reset, motor_cmd, right_drive, left_drive};

endmodule

>>> verif/tb_dual_axis_pid_move_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dual-axis PID move controller - self-checking testbench
// Opens with a directed table that covers field extremes, every request kind
// and the corner cases. Random move sequences follow under several gain and
// band settings, each aimed at the current targets so that moves settle. A
// built-in model of the controller predicts each response the table leaves open,
// and every response is compared field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_dual_axis_pid_move_controller;
   import dapm_pkg::*;

   localparam int         CYCLE_LIMIT     = 200000;
   localparam int         ITEMS_PER_PHASE = 125;
   localparam int         PHASES          = 6;
   localparam int         SETTLE_TICKS    = 3;
   localparam logic [1:0] ACT_UNUSED      = 2'd3;
   localparam int         ENC_MIN         = 32'sh8000_0000;
   localparam int         ENC_MAX         = 32'sh7FFF_FFFF;
   localparam longint     TERM_LIMIT      = 64'sh1000_0000_0000_0000;
   localparam longint     LAT_INT_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint     ROT_INT_MAX     = 64'sh0000_0000_7FFF_FFFF;
   localparam longint     FULL_TURN       = 5760;
   localparam longint     WRAP_LOW        = 1440;
   localparam longint     WRAP_HIGH       = 4320;
   localparam longint     FINE_LIMIT      = 80;

   localparam cfg_type DEFAULT_GAINS = '{
      lat_gain_p: 16'd6554,  lat_gain_i: 16'd0,   lat_gain_d: 16'd0,
      rot_gain_p: 16'd24379, rot_gain_i: 16'd341, rot_gain_d: 16'd13107,
      lat_tol:    16'd400,   rot_tol:    13'd48};

   typedef struct packed {
      logic signed [DRIVE_W-1:0] left_drive;
      logic signed [DRIVE_W-1:0] right_drive;
      motor_cmd_type             motor;
      sensor_reset_type          sense;
      logic                      done;
   } move_result_type;

   typedef struct {
      req_type         req;
      bit              typed;
      move_result_type want;
   } stim_row_type;

   logic         clock;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata  = '0;
   logic [1:0]   req_tuser  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;
   logic         csr_we     = 1'b0;
   logic [2:0]   csr_addr   = '0;
   logic [15:0]  csr_wdata  = '0;

   // controller model state
   cfg_type gains_now;
   longint  lat_target, rot_target, lat_prev_err, rot_prev_err;
   longint  lat_accum, rot_accum;
   bit      turning_left;
   int      settled_ticks;
   bit      move_active;

   move_result_type pending_responses[$];
   stim_row_type    directed_rows[$];
   int              mismatch_count;
   int              cycle_count = 0;
   int              sent_count;
   int              burst_left;
   bit              use_gaps;
   int              rx_mode = 0;
   int              rx_phase_left = 0;

   dual_axis_pid_move_controller u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint clamp64(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Weighted sum of the three terms, rounded and saturated to full drive
   function automatic longint pid_drive(longint err, longint accum, longint deriv,
                                        longint gp, longint gi, longint gd);
      longint sum;
      sum = clamp64(err * gp, -TERM_LIMIT, TERM_LIMIT)
          + clamp64(accum * gi, -TERM_LIMIT, TERM_LIMIT)
          + clamp64(deriv * gd, -TERM_LIMIT, TERM_LIMIT);
      return clamp64((sum + 2048) >>> 12, -DRIVE_MAX, DRIVE_MAX);
   endfunction

   // Advance the controller model by one request and return its response
   function automatic move_result_type compute_move_response(req_type r);
      move_result_type res;
      longint          m, pos, lat_err, rot_err, h, angle, v, lat_band, rot_band;
      longint          gd;
      res      = '0;
      m        = r.move_target;
      lat_band = gains_now.lat_tol;
      rot_band = gains_now.rot_tol;
      case (r.action)
         ACT_DRIVE: begin
            lat_target  = -((m * longint'(DRIVE_K_Q16) + 32768) >>> 16);
            move_active = 1'b1;
            res.sense   = SENSE_WHEELS;
         end
         ACT_ROTATE: begin
            angle        = clamp64(m, -FULL_TURN, FULL_TURN);
            rot_target   = (angle < 0) ? FULL_TURN + angle : angle;
            turning_left = (angle < 0);
            move_active  = 1'b1;
            res.sense    = SENSE_HEADING;
         end
         ACT_TICK: begin
            if (move_active) begin
               pos = (longint'(r.right_pos_a) + longint'(r.right_pos_b)
                    - longint'(r.left_pos_a) - longint'(r.left_pos_b) + 2) >>> 2;
               lat_err = lat_target - pos;
               h = r.heading;
               // unwrap the heading toward the turn direction
               if (turning_left) begin
                  if (h <= WRAP_LOW) h = h + FULL_TURN;
               end else if (h >= WRAP_HIGH) begin
                  h = h - FULL_TURN;
               end
               rot_err = rot_target - h;
               if (lat_target != 0 && ((lat_err < 0) ? -lat_err : lat_err) > lat_band) begin
                  settled_ticks = 0;
                  lat_accum = clamp64(lat_accum + lat_err, -LAT_INT_MAX - 1, LAT_INT_MAX);
                  v = pid_drive(lat_err, lat_accum, lat_err - lat_prev_err,
                                gains_now.lat_gain_p, gains_now.lat_gain_i,
                                gains_now.lat_gain_d);
                  res.left_drive  = DRIVE_W'(-v);
                  res.right_drive = DRIVE_W'(v);
                  res.motor       = MOTOR_SPIN;
                  lat_prev_err    = lat_err;
               end else if (rot_target != 0 &&
                            ((rot_err < 0) ? -rot_err : rot_err) > rot_band) begin
                  settled_ticks = 0;
                  gd = (rot_err < FINE_LIMIT && r.fine_damping) ? FINE_D_GAIN
                                                                : gains_now.rot_gain_d;
                  rot_accum = clamp64(rot_accum + rot_err, -ROT_INT_MAX - 1, ROT_INT_MAX);
                  v = pid_drive(rot_err, rot_accum, rot_err - rot_prev_err,
                                gains_now.rot_gain_p, gains_now.rot_gain_i, gd);
                  res.left_drive  = DRIVE_W'(v);
                  res.right_drive = DRIVE_W'(v);
                  res.motor       = MOTOR_SPIN;
                  rot_prev_err    = rot_err;
               end else begin
                  // count settled ticks, stop and clear the move on the last
                  settled_ticks++;
                  if (settled_ticks >= SETTLE_TICKS) begin
                     settled_ticks = 0;
                     move_active   = 1'b0;
                     lat_target    = 0;
                     rot_target    = 0;
                     lat_prev_err  = 0;
                     rot_prev_err  = 0;
                     res.motor     = MOTOR_STOP;
                  end
               end
            end
         end
         default: ;
      endcase
      res.done = !move_active;
      return res;
   endfunction

   function automatic void add_row(logic [1:0] act, int tgt, bit fine, int la, int lb,
                                   int ra, int rb, int hd, bit typed = 1'b0,
                                   motor_cmd_type mc = MOTOR_HOLD,
                                   sensor_reset_type sr = SENSE_NONE, bit done = 1'b0);
      stim_row_type row;
      row.req.action       = act;
      row.req.move_target  = TARGET_W'(tgt);
      row.req.fine_damping = fine;
      row.req.left_pos_a   = la;
      row.req.left_pos_b   = lb;
      row.req.right_pos_a  = ra;
      row.req.right_pos_b  = rb;
      row.req.heading      = HEAD_W'(hd);
      row.typed            = typed;
      row.want             = '0;
      row.want.motor       = mc;
      row.want.sense       = sr;
      row.want.done        = done;
      directed_rows.push_back(row);
   endfunction

   // Build a tick whose encoders and heading close in on the current targets
   function automatic req_type aimed_tick(int k, int n);
      req_type r;
      longint  pos, la, lb, ra, start, u;
      r              = '0;
      r.action       = ACT_TICK;
      r.move_target  = TARGET_W'($urandom);
      r.fine_damping = 1'($urandom_range(0, 1));
      pos = lat_target * k / n + longint'($urandom_range(0, 60)) - 30;
      la  = longint'($signed($urandom)) >>> 2;
      lb  = longint'($signed($urandom)) >>> 2;
      ra  = longint'($signed($urandom)) >>> 2;
      r.left_pos_a  = ENC_W'(la);
      r.left_pos_b  = ENC_W'(lb);
      r.right_pos_a = ENC_W'(ra);
      r.right_pos_b = ENC_W'(4 * pos + la + lb - ra);
      start = turning_left ? FULL_TURN : 0;
      u = start + (rot_target - start) * k / n + longint'($urandom_range(0, 40)) - 20;
      if (turning_left) begin
         u = clamp64(u, WRAP_LOW + 1, FULL_TURN + WRAP_LOW);
         r.heading = HEAD_W'((u >= FULL_TURN) ? u - FULL_TURN : u);
      end else begin
         u = clamp64(u, -WRAP_LOW, WRAP_HIGH - 1);
         r.heading = HEAD_W'((u < 0) ? u + FULL_TURN : u);
      end
      return r;
   endfunction

   function automatic req_type random_request();
      req_type r;
      r.action       = 2'($urandom_range(0, 3));
      r.move_target  = TARGET_W'($urandom);
      r.fine_damping = 1'($urandom_range(0, 1));
      r.left_pos_a   = $urandom;
      r.left_pos_b   = $urandom;
      r.right_pos_a  = $urandom;
      r.right_pos_b  = $urandom;
      r.heading      = HEAD_W'($urandom_range(0, 8191));
      return r;
   endfunction

   function automatic logic [GAIN_W-1:0] random_gain();
      return GAIN_W'($urandom_range(0, (1 << $urandom_range(4, 16)) - 1));
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Present one request in bursts with random gaps, and queue its response
   task automatic push_request(input req_type r, input bit typed,
                               input move_result_type typed_res);
      move_result_type predicted;
      int              gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = use_gaps ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= r.action;
      req_tdata  <= {1'b0, r.heading, r.right_pos_b, r.right_pos_a, r.left_pos_b,
                     r.left_pos_a, r.fine_damping, r.move_target};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = compute_move_response(r);
      pending_responses.push_back(typed ? typed_res : predicted);
      sent_count++;
   endtask

   // Drop valid and wait for every pending response, then idle for the given tail
   task automatic drain_pipeline(input int tail);
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_gains(input cfg_type g);
      write_csr(CSR_LAT_GAIN_P, g.lat_gain_p);
      write_csr(CSR_LAT_GAIN_I, g.lat_gain_i);
      write_csr(CSR_LAT_GAIN_D, g.lat_gain_d);
      write_csr(CSR_ROT_GAIN_P, g.rot_gain_p);
      write_csr(CSR_ROT_GAIN_I, g.rot_gain_i);
      write_csr(CSR_ROT_GAIN_D, g.rot_gain_d);
      write_csr(CSR_LAT_TOL, g.lat_tol);
      write_csr(CSR_ROT_TOL, {3'b000, g.rot_tol});
      csr_we    <= 1'b0;
      gains_now = g;
   endtask

   // Receiver readiness: switch between stall patterns every so often
   always @(posedge clock) begin
      if (rx_phase_left == 0) begin
         rx_mode       <= $urandom_range(0, 3);
         rx_phase_left <= $urandom_range(20, 200);
      end else begin
         rx_phase_left <= rx_phase_left - 1;
      end
      case (rx_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 7) != 0);
         default: rsp_tready <= ((rx_phase_left % 8) < 5);
      endcase
   end

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      move_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("response with none pending", rsp_tdata[36:0], 0);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_tdata[15:0] !== want.left_drive)
               report_mismatch("left_drive", $signed(rsp_tdata[15:0]), want.left_drive);
            if (rsp_tdata[31:16] !== want.right_drive)
               report_mismatch("right_drive", $signed(rsp_tdata[31:16]), want.right_drive);
            if (rsp_tdata[33:32] !== want.motor)
               report_mismatch("motor_cmd", rsp_tdata[33:32], want.motor);
            if (rsp_tdata[35:34] !== want.sense)
               report_mismatch("sensor_reset", rsp_tdata[35:34], want.sense);
            if (rsp_tdata[36] !== want.done)
               report_mismatch("move_done", rsp_tdata[36], want.done);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      cfg_type         g;
      req_type         r;
      move_result_type none;
      int              ph, phase_goal, sel, n, ticks, t, tgt, cnt;
      bit              broken;
      gains_now      = DEFAULT_GAINS;
      lat_target     = 0;
      rot_target     = 0;
      lat_prev_err   = 0;
      rot_prev_err   = 0;
      lat_accum      = 0;
      rot_accum      = 0;
      turning_left   = 1'b0;
      settled_ticks  = 0;
      move_active    = 1'b0;
      mismatch_count = 0;
      sent_count     = 0;
      burst_left     = 0;
      use_gaps       = 1'b1;
      none           = '0;

      // idle tick and unused kind after reset, then saturating drive moves
      add_row(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 1, MOTOR_HOLD, SENSE_NONE, 1);
      add_row(ACT_UNUSED, 65535, 1, ENC_MAX, ENC_MAX, ENC_MAX, ENC_MAX, 8191,
              1, MOTOR_HOLD, SENSE_NONE, 1);
      add_row(ACT_DRIVE, 65535, 0, 0, 0, 0, 0, 0, 1, MOTOR_HOLD, SENSE_WHEELS, 0);
      add_row(ACT_TICK, 0, 0, ENC_MIN, ENC_MIN, ENC_MAX, ENC_MAX, 0);
      add_row(ACT_TICK, 0, 1, ENC_MAX, ENC_MAX, ENC_MIN, ENC_MIN, 0);
      add_row(ACT_DRIVE, -65536, 0, 0, 0, 0, 0, 0, 1, MOTOR_HOLD, SENSE_WHEELS, 0);
      add_row(ACT_TICK, 0, 0, 0, 0, 0, 0, 0);
      // out-of-range angle clamps to a full left turn, i.e. no heading target
      add_row(ACT_ROTATE, -65536, 0, 0, 0, 0, 0, 0, 1, MOTOR_HOLD, SENSE_HEADING, 0);
      // land exactly on the drive target and settle
      add_row(ACT_TICK, 0, 0, 0, 0, 3754936, 3754936, 0, 1, MOTOR_HOLD, SENSE_NONE, 0);
      add_row(ACT_TICK, 0, 0, 0, 0, 3754936, 3754936, 0, 1, MOTOR_HOLD, SENSE_NONE, 0);
      add_row(ACT_TICK, 0, 0, 0, 0, 3754936, 3754936, 0, 1, MOTOR_STOP, SENSE_NONE, 1);
      // right turn past range, heading beyond range and unwrap
      add_row(ACT_ROTATE, 65535, 0, 0, 0, 0, 0, 0, 1, MOTOR_HOLD, SENSE_HEADING, 0);
      add_row(ACT_TICK, 0, 0, 0, 0, 0, 0, 8191);
      add_row(ACT_TICK, 0, 1, 0, 0, 0, 0, 0);
      // left turn with wrap at the low edge
      add_row(ACT_ROTATE, -1, 0, 0, 0, 0, 0, 0, 1, MOTOR_HOLD, SENSE_HEADING, 0);
      add_row(ACT_TICK, 0, 0, 0, 0, 0, 0, 1440);
      add_row(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 1, MOTOR_HOLD, SENSE_NONE, 0);
      // fine damping near target, both error signs, then coarse
      add_row(ACT_ROTATE, 100, 0, 0, 0, 0, 0, 0, 1, MOTOR_HOLD, SENSE_HEADING, 0);
      add_row(ACT_TICK, 0, 1, 0, 0, 0, 0, 30);
      add_row(ACT_TICK, 0, 1, 0, 0, 0, 0, 200);
      add_row(ACT_TICK, 0, 0, 0, 0, 0, 0, 30);
      // zero-length drive leaves only the heading target, which settles
      add_row(ACT_DRIVE, 0, 0, 0, 0, 0, 0, 0, 1, MOTOR_HOLD, SENSE_WHEELS, 0);
      add_row(ACT_TICK, 0, 0, 0, 0, 0, 0, 100, 1, MOTOR_HOLD, SENSE_NONE, 0);
      add_row(ACT_TICK, 0, 0, 0, 0, 0, 0, 100, 1, MOTOR_HOLD, SENSE_NONE, 0);
      add_row(ACT_TICK, 0, 0, 0, 0, 0, 0, 100, 1, MOTOR_STOP, SENSE_NONE, 1);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         push_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

      for (ph = 0; ph < PHASES; ph++) begin
         drain_pipeline(4);
         // pick the gains and bands for this phase
         case (ph)
            0: g = '0;
            1: g = '1;
            default: begin
               g.lat_gain_p = random_gain();
               g.lat_gain_i = random_gain();
               g.lat_gain_d = random_gain();
               g.rot_gain_p = random_gain();
               g.rot_gain_i = random_gain();
               g.rot_gain_d = random_gain();
               g.lat_tol    = GAIN_W'($urandom_range(0, 1000));
               g.rot_tol    = ROT_TOL_W'($urandom_range(0, 120));
            end
         endcase
         load_gains(g);
         use_gaps   = (ph % 3 != 2);
         phase_goal = sent_count + ITEMS_PER_PHASE;
         while (sent_count < phase_goal) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
               // noise: arbitrary requests of any kind
               cnt = $urandom_range(1, 4);
               repeat (cnt) push_request(random_request(), 1'b0, none);
            end else begin
               r = aimed_tick(1, 1);
               if ($urandom_range(0, 1) == 0) begin
                  r.action = ACT_DRIVE;
                  tgt = ($urandom_range(0, 6) != 0) ? int'($urandom_range(0, 1600)) - 800
                                                    : int'($urandom);
               end else begin
                  r.action = ACT_ROTATE;
                  tgt = ($urandom_range(0, 6) != 0) ? int'($urandom_range(0, 11520)) - 5760
                                                    : int'($urandom);
               end
               r.move_target = TARGET_W'(tgt);
               push_request(r, 1'b0, none);
               // close in on the target, then hold; a broken move stops early
               n      = $urandom_range(2, 10);
               broken = (sel == 1);
               ticks  = broken ? $urandom_range(0, n - 1) : n + $urandom_range(3, 5);
               for (t = 1; t <= ticks; t++)
                  push_request(aimed_tick((t < n) ? t : n, n), 1'b0, none);
            end
         end
      end

      drain_pipeline(8);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> dual_axis_pid_move_controller.f
src/dapm_pkg.sv
src/dapm_cfg_regs.sv
src/dapm_ctrl.sv
src/dapm_drive.sv
src/dual_axis_pid_move_controller.sv
verif/tb_dual_axis_pid_move_controller.sv
